[design/tcw_pkg.sv]
// Shared types and constants of the text console writer.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package tcw_pkg;

   localparam int MAX_COLUMNS = 80;
   localparam int MAX_ROWS    = 25;
   localparam int STORE_CELLS = MAX_COLUMNS * MAX_ROWS;

   localparam int COL_W  = 7;
   localparam int ROW_W  = 5;
   localparam int IDX_W  = 11;
   localparam int CELL_W = 16;

   localparam logic [7:0]        NEWLINE_CODE = 8'd10;
   localparam logic [CELL_W-1:0] BLANK_CELL   = 16'h0f20;
   localparam logic [IDX_W-1:0]  LAST_CELL    = IDX_W'(STORE_CELLS - 1);

   // two-entry queue between front and back
   localparam int QUEUE_AW    = 1;
   localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

   typedef enum logic [1:0] {
      OP_PUT   = 2'd0,
      OP_CLEAR = 2'd1,
      OP_READ  = 2'd2,
      OP_SPARE = 2'd3
   } tcw_op_type;

   typedef enum logic [2:0] {
      K_PUT     = 3'd0,
      K_NEWLINE = 3'd1,
      K_CLEAR   = 3'd2,
      K_READ    = 3'd3,
      K_NOP     = 3'd4
   } tcw_kind_type;

   typedef struct packed {
      tcw_kind_type     kind;
      logic [7:0]       char_code;
      logic [7:0]       attr;
      logic [IDX_W-1:0] cell_index;
      logic             in_range;
   } tcw_item_type;

   typedef struct packed {
      logic [COL_W-1:0] width;
      logic [ROW_W-1:0] rows;
   } tcw_geom_type;

endpackage

`default_nettype wire

[design/tcw_if.sv]
// Request and response channels of the text console writer.
// Depends on tcw_pkg for field widths.
`default_nettype none

interface tcw_req_if
   import tcw_pkg::*;
   ();
   logic             valid;
   logic             ready;
   logic [1:0]       op;
   logic [7:0]       char_code;
   logic [3:0]       fg_color;
   logic [3:0]       bg_color;
   logic [IDX_W-1:0] cell_index;

   modport source (output valid, op, char_code, fg_color, bg_color, cell_index,
                   input ready);
   modport sink   (input valid, op, char_code, fg_color, bg_color, cell_index,
                   output ready);
endinterface

interface tcw_rsp_if
   import tcw_pkg::*;
   ();
   logic             valid;
   logic             ready;
   logic [IDX_W-1:0] cursor_index;
   logic [COL_W-1:0] cursor_col;
   logic [ROW_W-1:0] cursor_row;
   logic             scrolled;
   logic [7:0]       cell_char;
   logic [7:0]       cell_attr;

   modport source (output valid, cursor_index, cursor_col, cursor_row, scrolled,
                   cell_char, cell_attr, input ready);
   modport sink   (input valid, cursor_index, cursor_col, cursor_row, scrolled,
                   cell_char, cell_attr, output ready);
endinterface

`default_nettype wire

[design/text_console_writer_core.sv]
// Text console writer: a screen store of 80x25 character/attribute cells with a
// cursor that writes, wraps and scrolls. After reset the store is cleared by a
// sweep over the whole store, during which no request beat is taken; configuration
// writes are taken as ever. Each request gives exactly one response beat. A put
// or newline that scrolls copies the rows up and fills the bottom row with blanks,
// one store word per cycle through the single write port. A clear writes one cell
// a cycle over the whole store. Two decoded requests can wait in the queue ahead
// of the execution stage, so the front keeps taking beats while a scroll or clear
// runs. Write line_width and line_count only while idle.
//
// Depends on tcw_pkg, tcw_if, tcw_front, tcw_queue and tcw_back.
`default_nettype none

module text_console_writer_core
   import tcw_pkg::*;
   (
   input  wire logic             clock,
   input  wire logic             reset,
   tcw_req_if.sink               req_bus,
   tcw_rsp_if.source             rsp_bus,
   input  wire logic             csr_we,
   input  wire logic             csr_index,
   input  wire logic [COL_W-1:0] csr_wdata
   );

   localparam logic CSR_LINE_WIDTH = 1'b0;
   localparam logic CSR_LINE_COUNT = 1'b1;

   logic [COL_W-1:0] line_width_ff;
   logic [ROW_W-1:0] line_count_ff;
   tcw_geom_type     geom;

   tcw_item_type push_item, head;
   logic         push, pop, q_full, q_not_empty, init_busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         line_width_ff <= COL_W'(MAX_COLUMNS);
         line_count_ff <= ROW_W'(MAX_ROWS);
      end else if (csr_we) begin
         case (csr_index)
            CSR_LINE_WIDTH: line_width_ff <= csr_wdata;
            CSR_LINE_COUNT: line_count_ff <= csr_wdata[ROW_W-1:0];
            default: ;
         endcase
      end
   end

   // clamp the geometry in use to the store size
   always_comb begin
      if (line_width_ff == '0) begin
         geom.width = COL_W'(1);
      end else if (line_width_ff > COL_W'(MAX_COLUMNS)) begin
         geom.width = COL_W'(MAX_COLUMNS);
      end else begin
         geom.width = line_width_ff;
      end
      if (line_count_ff == '0) begin
         geom.rows = ROW_W'(1);
      end else if (line_count_ff > ROW_W'(MAX_ROWS)) begin
         geom.rows = ROW_W'(MAX_ROWS);
      end else begin
         geom.rows = line_count_ff;
      end
   end

   tcw_front u_front (
      .req_bus    (req_bus),
      .queue_full (q_full),
      .init_busy  (init_busy),
      .push_item  (push_item),
      .push       (push)
   );

   tcw_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .full      (q_full),
      .not_empty (q_not_empty),
      .head      (head)
   );

   tcw_back u_back (
      .clock      (clock),
      .reset      (reset),
      .geom       (geom),
      .item_valid (q_not_empty),
      .item       (head),
      .pop        (pop),
      .init_busy  (init_busy),
      .rsp_bus    (rsp_bus)
   );

   a_no_beat_in_init: assert property (@(posedge clock) disable iff (reset)
      init_busy |-> !(req_bus.valid && req_bus.ready))
      else $error("request beat taken during store initialisation");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      q_full && !pop |=> !q_full || $stable(head))
      else $error("queue head changed while full without a pop");

   a_scroll_col_home: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.scrolled |-> rsp_bus.cursor_col == '0)
      else $error("scrolled response with cursor off column 0");

   a_scroll_bottom_row: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.scrolled |-> rsp_bus.cursor_row == geom.rows - 1'b1)
      else $error("scrolled response with cursor off the bottom row");

endmodule

`default_nettype wire

[design/tcw_front.sv]
// Front end: takes request beats and decodes them into queue items.
// Depends on tcw_pkg and tcw_req_if.
`default_nettype none

module tcw_front
   import tcw_pkg::*;
   (
   tcw_req_if.sink      req_bus,
   input  wire logic    queue_full,
   input  wire logic    init_busy,
   output tcw_item_type push_item,
   output logic         push
   );

   tcw_op_type op_code;

   assign op_code       = tcw_op_type'(req_bus.op);
   assign req_bus.ready = !queue_full && !init_busy;
   assign push          = req_bus.valid && req_bus.ready;

   always_comb begin
      push_item.char_code  = req_bus.char_code;
      push_item.attr       = {req_bus.bg_color, req_bus.fg_color};
      push_item.cell_index = req_bus.cell_index;
      push_item.in_range   = req_bus.cell_index <= LAST_CELL;
      case (op_code)
         OP_PUT: begin
            push_item.kind = (req_bus.char_code == NEWLINE_CODE) ? K_NEWLINE : K_PUT;
         end
         OP_CLEAR: push_item.kind = K_CLEAR;
         OP_READ:  push_item.kind = K_READ;
         default:  push_item.kind = K_NOP;
      endcase
   end

endmodule

`default_nettype wire

[design/tcw_queue.sv]
// Short item queue between the decode front and the execution back.
// Depends on tcw_pkg.
`default_nettype none

module tcw_queue
   import tcw_pkg::*;
   (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         push,
   input  wire tcw_item_type push_item,
   input  wire logic         pop,
   output logic             full,
   output logic             not_empty,
   output tcw_item_type     head
   );

   tcw_item_type          slot_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]     count_ff, count_in;

   assign full      = count_ff == (QUEUE_AW+1)'(QUEUE_DEPTH);
   assign not_empty = count_ff != '0;
   assign head      = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

[design/tcw_back.sv]
// Back end: cursor logic, screen store, scroll and clear sweeps, result register.
// Depends on tcw_pkg and tcw_rsp_if.
`default_nettype none

module tcw_back
   import tcw_pkg::*;
   (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire tcw_geom_type geom,
   input  wire logic         item_valid,
   input  wire tcw_item_type item,
   output logic              pop,
   output logic              init_busy,
   tcw_rsp_if.source         rsp_bus
   );

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_EXEC   = 6'b000010,
      ST_SCROLL = 6'b000100,
      ST_SWEEP  = 6'b001000,
      ST_READ   = 6'b010000,
      ST_DONE   = 6'b100000
   } tcw_state_type;

   tcw_state_type    state_ff, state_in;
   tcw_item_type     item_ff, item_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [IDX_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [IDX_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [IDX_W-1:0] hw_ff, hw_in;
   logic             pend_ff, pend_in;
   logic             sweep_rsp_ff, sweep_rsp_in;
   logic             scrolled_ff, scrolled_in;
   logic [7:0]       cchar_ff, cchar_in;
   logic [7:0]       cattr_ff, cattr_in;

   logic             out_valid_ff, out_valid_in;
   logic [IDX_W-1:0] out_index_ff, out_index_in;
   logic [COL_W-1:0] out_col_ff, out_col_in;
   logic [ROW_W-1:0] out_row_ff, out_row_in;
   logic             out_scrolled_ff, out_scrolled_in;
   logic [7:0]       out_char_ff, out_char_in;
   logic [7:0]       out_attr_ff, out_attr_in;

   logic [CELL_W-1:0] store_mem [STORE_CELLS];
   logic [CELL_W-1:0] rdata_ff;
   logic              mem_we, mem_re;
   logic [IDX_W-1:0]  mem_wa, mem_ra;
   logic [CELL_W-1:0] mem_wd;

   // cursor arithmetic
   logic [IDX_W:0]   lin;
   logic [IDX_W:0]   area;
   logic [COL_W:0]   col_step, col_wr;
   logic [ROW_W:0]   row_step, row_wr;
   logic             wrap, need_scroll, put_hit, rd_more;

   assign lin  = (IDX_W+1)'(row_ff) * (IDX_W+1)'(geom.width) + (IDX_W+1)'(col_ff);
   assign area = (IDX_W+1)'(geom.rows) * (IDX_W+1)'(geom.width);

   assign col_step    = (item_ff.kind == K_NEWLINE) ? '0 : {1'b0, col_ff} + 1'b1;
   assign row_step    = (item_ff.kind == K_NEWLINE) ? {1'b0, row_ff} + 1'b1 : {1'b0, row_ff};
   assign wrap        = col_step >= {1'b0, geom.width};
   assign col_wr      = wrap ? '0 : col_step;
   assign row_wr      = wrap ? row_step + 1'b1 : row_step;
   assign need_scroll = row_wr >= {1'b0, geom.rows};
   assign put_hit     = (col_ff < geom.width) && (row_ff < geom.rows);
   assign rd_more     = rd_ptr_ff < hw_ff;

   assign init_busy = (state_ff == ST_SWEEP) && !sweep_rsp_ff;

   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      rd_ptr_in    = rd_ptr_ff;
      wr_ptr_in    = wr_ptr_ff;
      hw_in        = hw_ff;
      pend_in      = 1'b0;
      sweep_rsp_in = sweep_rsp_ff;
      scrolled_in  = scrolled_ff;
      cchar_in     = cchar_ff;
      cattr_in     = cattr_ff;
      out_valid_in    = out_valid_ff && !rsp_bus.ready;
      out_index_in    = out_index_ff;
      out_col_in      = out_col_ff;
      out_row_in      = out_row_ff;
      out_scrolled_in = out_scrolled_ff;
      out_char_in     = out_char_ff;
      out_attr_in     = out_attr_ff;
      mem_we = 1'b0;
      mem_wa = wr_ptr_ff;
      mem_wd = '0;
      mem_re = 1'b0;
      mem_ra = rd_ptr_ff;
      pop    = 1'b0;

      case (state_ff)
         ST_SWEEP: begin
            mem_we    = 1'b1;
            wr_ptr_in = wr_ptr_ff + 1'b1;
            if (wr_ptr_ff == LAST_CELL) begin
               wr_ptr_in    = '0;
               sweep_rsp_in = 1'b0;
               state_in     = sweep_rsp_ff ? ST_DONE : ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (item_valid && !out_valid_ff) begin
               pop         = 1'b1;
               item_in     = item;
               scrolled_in = 1'b0;
               cchar_in    = '0;
               cattr_in    = '0;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            case (item_ff.kind)
               K_PUT, K_NEWLINE: begin
                  if (item_ff.kind == K_PUT && put_hit) begin
                     mem_we = 1'b1;
                     mem_wa = lin[IDX_W-1:0];
                     mem_wd = {item_ff.attr, item_ff.char_code};
                  end
                  if (need_scroll) begin
                     scrolled_in = 1'b1;
                     col_in      = '0;
                     row_in      = geom.rows - 1'b1;
                     rd_ptr_in   = IDX_W'(geom.width);
                     wr_ptr_in   = '0;
                     hw_in       = area[IDX_W-1:0];
                     state_in    = ST_SCROLL;
                  end else begin
                     col_in   = col_wr[COL_W-1:0];
                     row_in   = row_wr[ROW_W-1:0];
                     state_in = ST_DONE;
                  end
               end
               K_CLEAR: begin
                  col_in       = '0;
                  row_in       = '0;
                  wr_ptr_in    = '0;
                  sweep_rsp_in = 1'b1;
                  state_in     = ST_SWEEP;
               end
               K_READ: begin
                  if (item_ff.in_range) begin
                     mem_re   = 1'b1;
                     mem_ra   = item_ff.cell_index;
                     state_in = ST_READ;
                  end else begin
                     state_in = ST_DONE;
                  end
               end
               default: state_in = ST_DONE;
            endcase
         end
         ST_SCROLL: begin
            // read one row ahead, write the beat read in the previous cycle
            if (rd_more) begin
               mem_re    = 1'b1;
               rd_ptr_in = rd_ptr_ff + 1'b1;
               pend_in   = 1'b1;
            end
            if (pend_ff) begin
               mem_we    = 1'b1;
               mem_wd    = rdata_ff;
               wr_ptr_in = wr_ptr_ff + 1'b1;
            end else if (!rd_more) begin
               // bottom row: fill with blanks, then finish
               if (wr_ptr_ff < hw_ff) begin
                  mem_we    = 1'b1;
                  mem_wd    = BLANK_CELL;
                  wr_ptr_in = wr_ptr_ff + 1'b1;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_READ: begin
            cchar_in = rdata_ff[7:0];
            cattr_in = rdata_ff[15:8];
            state_in = ST_DONE;
         end
         ST_DONE: begin
            out_valid_in    = 1'b1;
            out_index_in    = lin[IDX_W-1:0];
            out_col_in      = col_ff;
            out_row_in      = row_ff;
            out_scrolled_in = scrolled_ff;
            out_char_in     = cchar_ff;
            out_attr_in     = cattr_ff;
            state_in        = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SWEEP;
         col_ff       <= '0;
         row_ff       <= '0;
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         pend_ff      <= 1'b0;
         sweep_rsp_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         pend_ff      <= pend_in;
         sweep_rsp_ff <= sweep_rsp_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff         <= item_in;
      hw_ff           <= hw_in;
      scrolled_ff     <= scrolled_in;
      cchar_ff        <= cchar_in;
      cattr_ff        <= cattr_in;
      out_index_ff    <= out_index_in;
      out_col_ff      <= out_col_in;
      out_row_ff      <= out_row_in;
      out_scrolled_ff <= out_scrolled_in;
      out_char_ff     <= out_char_in;
      out_attr_ff     <= out_attr_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[mem_wa] <= mem_wd;
      end
      if (mem_re) begin
         rdata_ff <= store_mem[mem_ra];
      end
   end

   assign rsp_bus.valid        = out_valid_ff;
   assign rsp_bus.cursor_index = out_index_ff;
   assign rsp_bus.cursor_col   = out_col_ff;
   assign rsp_bus.cursor_row   = out_row_ff;
   assign rsp_bus.scrolled     = out_scrolled_ff;
   assign rsp_bus.cell_char    = out_char_ff;
   assign rsp_bus.cell_attr    = out_attr_ff;

endmodule

`default_nettype wire
